/* design/rhls_pkg.sv */
// rhls_pkg: shared widths for the rgb to hls pixel converter
// used by rhls_div and rgb_to_hls_pixel; no dependencies

package rhls_pkg;

    // colour component width
    localparam int COMP_W = 8;
    // divisor and remainder width of the pipelined divider
    localparam int DIV_W  = 8;
    // quotient width, also the number of divider stages
    localparam int QUO_W  = 8;
    // dividend width
    localparam int NUM_W  = DIV_W + QUO_W;

endpackage

/* design/rhls_div.sv */
// rhls_div: pipelined restoring divider, one quotient bit per register stage
// depends on rhls_pkg; the quotient must fit in QUO_W bits (num < den << QUO_W)

module rhls_div
    import rhls_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int Steps = QUO_W;

    logic [DIV_W-1:0] rem_reg [Steps-1];
    logic [DIV_W-1:0] low_reg [Steps-1];
    logic [DIV_W-1:0] den_reg [Steps-1];
    logic [QUO_W-1:0] quo_reg [Steps];

    for (genvar k = 0; k < Steps; k++)
    begin : g_step
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] low_in;
        logic [DIV_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [DIV_W:0]   trial;
        logic [DIV_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = num[NUM_W-1:QUO_W];
            assign low_in = num[QUO_W-1:0];
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // shift in the next dividend bit and try the subtraction
        assign trial = {rem_in, low_in[DIV_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= {quo_in[QUO_W-2:0], ge};
        end

        if (k < Steps - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                low_reg[k] <= {low_in[DIV_W-2:0], 1'b0};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[Steps-1];

endmodule

/* design/rgb_to_hls_pixel.sv */
// rgb_to_hls_pixel: 8-bit bgr pixel to hls (half-degree hue), fully pipelined
// an accepted request passes stages 1 to 3 and then the divider stages to result_valid
// throughput one request per cycle; busy is never raised, the pipeline has no stall
// the two divisions run in rhls_div, one quotient bit per stage, and set the depth
// rst_n clears only the valid bits; results are not held, result_valid pulses once
// depends on rhls_pkg and rhls_div

module rgb_to_hls_pixel
    import rhls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [COMP_W-1:0] blue,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] red,
    output logic              result_valid,
    output logic [QUO_W-1:0]  hue_half_deg,
    output logic [COMP_W-1:0] lightness,
    output logic [QUO_W-1:0]  saturation
);

    // hue numerator before scaling: at most 6 * 255
    localparam int X_W = COMP_W + 3;

    // which component is largest; red wins ties over green, green over blue
    typedef enum logic [2:0] {
        MAX_RED   = 3'b001,
        MAX_GREEN = 3'b010,
        MAX_BLUE  = 3'b100
    } max_sel_t;

    // ------------------------------------------------------------------
    // stage 1: find largest and smallest component
    // ------------------------------------------------------------------
    logic              v1_reg;
    logic [COMP_W-1:0] mx1_reg, mn1_reg;
    logic [COMP_W-1:0] b1_reg, g1_reg, r1_reg;
    max_sel_t          sel1_reg;

    max_sel_t          sel1_next;
    logic [COMP_W-1:0] mx1_next, mn1_next;

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sel1_next = MAX_RED;
            mx1_next  = red;
        end
        else if (green >= blue)
        begin
            sel1_next = MAX_GREEN;
            mx1_next  = green;
        end
        else
        begin
            sel1_next = MAX_BLUE;
            mx1_next  = blue;
        end

        mn1_next = red;
        if (green < mn1_next)
            mn1_next = green;
        if (blue < mn1_next)
            mn1_next = blue;
    end

    always_ff @(posedge clk)
    begin
        mx1_reg  <= mx1_next;
        mn1_reg  <= mn1_next;
        sel1_reg <= sel1_next;
        b1_reg   <= blue;
        g1_reg   <= green;
        r1_reg   <= red;
    end

    // ------------------------------------------------------------------
    // stage 2: range, sum, lightness, saturation divisor, hue sector offset
    // ------------------------------------------------------------------
    logic              v2_reg;
    logic [COMP_W-1:0] d2_reg;
    logic [COMP_W-1:0] light2_reg;
    logic [DIV_W-1:0]  sden2_reg;
    logic [X_W-1:0]    x2_reg;

    logic [COMP_W:0]   s2_next;
    logic [COMP_W-1:0] d2_next;
    logic [DIV_W-1:0]  sden2_next;
    logic [X_W-1:0]    x2_next;
    logic [X_W-1:0]    dx, bx, gx, rx;
    logic [COMP_W:0]   sflip;

    always_comb
    begin
        d2_next = mx1_reg - mn1_reg;
        s2_next = {1'b0, mx1_reg} + {1'b0, mn1_reg};
        sflip   = 9'(2 * 255) - s2_next;

        // saturation divisor: s below mid grey, 510 - s above
        if (s2_next < 9'd255)
            sden2_next = s2_next[DIV_W-1:0];
        else
            sden2_next = sflip[DIV_W-1:0];

        dx = {3'b000, d2_next};
        bx = {3'b000, b1_reg};
        gx = {3'b000, g1_reg};
        rx = {3'b000, r1_reg};

        // hue in sixths of a turn times d; every case ends non-negative
        unique case (sel1_reg)
            MAX_RED:
            begin
                if (g1_reg >= b1_reg)
                    x2_next = gx - bx;
                else
                    x2_next = (dx << 2) + (dx << 1) + gx - bx;  // wrap below zero
            end
            MAX_GREEN: x2_next = (dx << 1) + bx - rx;
            MAX_BLUE:  x2_next = (dx << 2) + rx - gx;
            default:   x2_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        d2_reg     <= d2_next;
        light2_reg <= s2_next[COMP_W:1];
        sden2_reg  <= sden2_next;
        x2_reg     <= x2_next;
    end

    // ------------------------------------------------------------------
    // stage 3: scale numerators, force grey pixels to a zero quotient
    // ------------------------------------------------------------------
    logic              v3_reg;
    logic [COMP_W-1:0] light3_reg;
    logic [NUM_W-1:0]  snum3_reg, hnum3_reg;
    logic [DIV_W-1:0]  sden3_reg, hden3_reg;

    logic [NUM_W-1:0]  dn, xn;
    logic              grey;

    always_comb
    begin
        dn   = {{(NUM_W-COMP_W){1'b0}}, d2_reg};
        xn   = {{(NUM_W-X_W){1'b0}}, x2_reg};
        grey = (d2_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        light3_reg <= light2_reg;
        if (grey)
        begin
            // 0 / 1 keeps the divider defined and gives zero hue and saturation
            snum3_reg <= '0;
            hnum3_reg <= '0;
            sden3_reg <= DIV_W'(1);
            hden3_reg <= DIV_W'(1);
        end
        else
        begin
            snum3_reg <= (dn << 8) - dn;        // 255 * d
            hnum3_reg <= (xn << 5) - (xn << 1); // 30 * x, hue / 2 over d
            sden3_reg <= sden2_reg;
            hden3_reg <= d2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stages 4 .. 3 + QUO_W: the two dividers
    // ------------------------------------------------------------------
    rhls_div u_sat_div (
        .clk (clk),
        .num (snum3_reg),
        .den (sden3_reg),
        .quo (saturation)
    );

    rhls_div u_hue_div (
        .clk (clk),
        .num (hnum3_reg),
        .den (hden3_reg),
        .quo (hue_half_deg)
    );

    // lightness rides alongside the dividers
    logic [COMP_W-1:0] light_dly_reg [QUO_W];

    always_ff @(posedge clk)
    begin
        light_dly_reg[0] <= light3_reg;
        for (int i = 1; i < QUO_W; i++)
            light_dly_reg[i] <= light_dly_reg[i-1];
    end

    assign lightness = light_dly_reg[QUO_W-1];

    // ------------------------------------------------------------------
    // valid bits, the only reset state
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] vdiv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vdiv_reg <= '0;
        end
        else
        begin
            v1_reg   <= start & ~busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vdiv_reg <= {vdiv_reg[QUO_W-2:0], v3_reg};
        end
    end

    assign result_valid = vdiv_reg[QUO_W-1];

    // every stage advances each cycle, so a request is always taken
    assign busy = 1'b0;

`ifndef NO_ASSERTIONS
    // hue never reaches a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> hue_half_deg < QUO_W'(180))
        else $error("hue out of range");

    // zero saturation only comes from a grey pixel, which has zero hue
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturation == '0 |-> hue_half_deg == '0)
        else $error("grey pixel with non-zero hue");

    // a grey pixel reaching stage 3 leaves both dividers a zero numerator
    a_grey_num: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && d2_reg == '0 |=> snum3_reg == '0 && hnum3_reg == '0)
        else $error("grey pixel not masked");
`endif

endmodule
